/* src/ffa_pkg.sv */
// Package for the first-fit heap allocator: defaults, status and request codes, and sequencer states.
package ffa_pkg;

    // Default heap geometry (powers of two)
    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int ALIGN_BYTES_DEF  = 8;
    localparam int HEADER_BYTES_DEF = 8;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_FREED      = 2'd2,
        ST_FREE_IGN   = 2'd3
    } t_status;

    // Request codes
    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_A_RD,
        S_A_EVAL,
        S_A_UNLINK,
        S_A_BLKW,
        S_F_RD,
        S_F_EVAL,
        S_P_CHK,
        S_P_RD,
        S_P_NRD,
        S_P_MRG,
        S_P_LINK,
        S_DONE
    } t_state;

endpackage

/* src/ffa_if.sv */
// Handshake interfaces for the allocator request and response channels.
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] request_bytes;
    logic [11:0] payload_offset;

    modport source (output valid, action, request_bytes, payload_offset, input ready);
    modport sink   (input valid, action, request_bytes, payload_offset, output ready);
endinterface

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] result_offset;
    logic [11:0] free_bytes;
    logic [11:0] min_free_bytes;

    modport source (output valid, status, result_offset, free_bytes, min_free_bytes,
                    input ready);
    modport sink   (input valid, status, result_offset, free_bytes, min_free_bytes,
                    output ready);
endinterface

/* src/first_fit_heap_allocator.sv */
// First-fit heap allocator with coalescing; block headers kept in one header memory.
//
// Usage:
//   i_req carries one request item: action (0 allocate, 1 free), request_bytes and
//   payload_offset. o_rsp returns exactly one result item per request: status,
//   result_offset, free_bytes and min_free_bytes.
//   Requests are handled one at a time by a sequencer around a single-port-read
//   header memory with a registered read. Each header visited takes a read state
//   and an evaluate state. Allocate walks the free list from the head (S_A_RD,
//   S_A_EVAL) to the first block that fits, unlinks it (S_A_UNLINK) and writes its
//   header (S_A_BLKW); a split then reinserts the remainder by the reinsertion walk
//   (S_P_CHK, S_P_RD, S_P_NRD) and merge (S_P_MRG, S_P_LINK). Free checks the header
//   (S_F_RD, S_F_EVAL), then runs the same reinsertion walk. A request rejected up
//   front, a rejected free and a failed allocate go on to S_DONE without changing the
//   heap. The next request is taken only back in S_IDLE; the free-list length sets the item time.
//   After reset the block runs a clearing pass over the header memory, one header per
//   cycle over all HEAP_BYTES/ALIGN_BYTES headers (512 by default), with i_req.ready low.
//   Results sit in an output register; a new request is taken while a result waits,
//   and the sequencer holds its finished result until the register is free.
//   ALIGN_BYTES and HEAP_BYTES are to be powers of two; the block does not check this.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffa_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ffa_req_if.sink        i_req,
    ffa_rsp_if.source      o_rsp
);

    localparam int GRANULES  = HEAP_BYTES / ALIGN_BYTES;
    localparam int GW        = $clog2(GRANULES);
    localparam int SW        = $clog2(HEAP_BYTES + 1);
    localparam int AW        = SW + 1;
    localparam int ALSH      = $clog2(ALIGN_BYTES);
    localparam int STW       = $clog2(GRANULES + 2);
    localparam int END_G     = (HEAP_BYTES - HEADER_BYTES) / ALIGN_BYTES;
    localparam int INIT_FREE = END_G * ALIGN_BYTES;
    localparam int SPLIT_MIN = HEADER_BYTES * 2;

    typedef struct packed {
        logic [SW-1:0] size;
        logic [GW-1:0] next;
        logic          linked;
        logic          used;
    } t_hdr;

    // Byte address of a granule, widened for compares
    function automatic logic [AW-1:0] gaddr(input logic [GW-1:0] g);
        return AW'({g, {ALSH{1'b0}}});
    endfunction

    // Header memory
    t_hdr          mem [GRANULES];
    t_hdr          r_rdata;
    logic          mem_we;
    logic [GW-1:0] mem_waddr;
    t_hdr          mem_wdata;
    logic          mem_re;
    logic [GW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Control and working registers
    ffa_pkg::t_state  r_state, n_state;
    logic [GW-1:0]    r_clr, n_clr;
    logic [GW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_free, n_free;
    logic [SW-1:0]    r_min, n_min;
    logic [GW-1:0]    r_blk, n_blk;
    logic [GW-1:0]    r_prev, n_prev;
    logic             r_athead, n_athead;
    logic [STW-1:0]   r_steps, n_steps;
    logic [SW-1:0]    r_want, n_want;
    t_hdr             r_hb, n_hb;
    t_hdr             r_hp, n_hp;
    logic             r_split, n_split;
    logic [GW-1:0]    r_b, n_b;
    logic [SW-1:0]    r_bsize, n_bsize;
    logic [GW-1:0]    r_it, n_it;
    logic [GW-1:0]    r_nxt, n_nxt;
    t_hdr             r_hit, n_hit;
    t_hdr             r_pb, n_pb;
    ffa_pkg::t_status r_status, n_status;
    logic [11:0]      r_result, n_result;

    // Output register
    logic             r_ovalid, n_ovalid;
    ffa_pkg::t_status r_ostatus, n_ostatus;
    logic [11:0]      r_oresult, n_oresult;
    logic [11:0]      r_ofree, n_ofree;
    logic [11:0]      r_omin, n_omin;

    // Request front checks
    logic [17:0] req_sum;
    logic [17:0] req_want;
    logic        req_ok;
    logic        alloc_go;
    logic [31:0] f_base;
    logic [31:0] f_gran;
    logic        free_go;

    always_comb begin
        req_sum  = 18'(i_req.request_bytes) + 18'(HEADER_BYTES);
        req_want = (req_sum + 18'(ALIGN_BYTES - 1)) & ~18'(ALIGN_BYTES - 1);
        req_ok   = (i_req.request_bytes != 16'd0)
                && (32'(i_req.request_bytes) <= 32'(HEAP_BYTES - HEADER_BYTES));
        alloc_go = req_ok && (32'(req_want) <= 32'(r_free));
        f_base   = 32'(i_req.payload_offset) - 32'(HEADER_BYTES);
        f_gran   = f_base >> ALSH;
        free_go  = (i_req.payload_offset != 12'd0)
                && (32'(i_req.payload_offset) >= 32'(HEADER_BYTES))
                && (f_base[ALSH-1:0] == '0)
                && (f_gran < 32'(GRANULES));
    end

    // Helpers for the walk, split and merge decisions
    logic          walk_more;
    logic [SW-1:0] split_rem;
    logic          merge_next;
    logic          merge_prev;
    t_hdr          pb_new;

    always_comb begin
        walk_more  = (r_rdata.size < r_want) && r_rdata.linked
                  && (32'(r_steps) <= 32'(GRANULES));
        split_rem  = r_hb.size - r_want;
        merge_next = (gaddr(r_b) + AW'(r_bsize)) == gaddr(r_nxt);
        merge_prev = !r_athead && ((gaddr(r_it) + AW'(r_hit.size)) == gaddr(r_b));
        pb_new.used = 1'b0;
        if (merge_next) begin
            if (r_nxt != GW'(END_G)) begin
                pb_new.size   = r_bsize + r_rdata.size;
                pb_new.next   = r_rdata.next;
                pb_new.linked = r_rdata.linked;
            end else begin
                pb_new.size   = r_bsize;
                pb_new.next   = GW'(END_G);
                pb_new.linked = 1'b1;
            end
        end else begin
            pb_new.size   = r_bsize;
            pb_new.next   = r_nxt;
            pb_new.linked = 1'b1;
        end
    end

    // Sequencer: next state, memory accesses and register updates
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_head    = r_head;
        n_free    = r_free;
        n_min     = r_min;
        n_blk     = r_blk;
        n_prev    = r_prev;
        n_athead  = r_athead;
        n_steps   = r_steps;
        n_want    = r_want;
        n_hb      = r_hb;
        n_hp      = r_hp;
        n_split   = r_split;
        n_b       = r_b;
        n_bsize   = r_bsize;
        n_it      = r_it;
        n_nxt     = r_nxt;
        n_hit     = r_hit;
        n_pb      = r_pb;
        n_status  = r_status;
        n_result  = r_result;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_ostatus = r_ostatus;
        n_oresult = r_oresult;
        n_ofree   = r_ofree;
        n_omin    = r_omin;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        i_req.ready = 1'b0;

        unique case (r_state)
            // Reset sweep: every header zero but the first free block
            ffa_pkg::S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == '0) begin
                    mem_wdata.size   = SW'(INIT_FREE);
                    mem_wdata.next   = GW'(END_G);
                    mem_wdata.linked = 1'b1;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == GW'(GRANULES - 1)) begin
                    n_state = ffa_pkg::S_IDLE;
                end
            end

            ffa_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_result = '0;
                    n_athead = 1'b1;
                    n_steps  = '0;
                    n_prev   = '0;
                    if (i_req.action == ffa_pkg::ACT_ALLOC) begin
                        n_status = ffa_pkg::ST_ALLOC_FAIL;
                        n_want   = SW'(req_want);
                        n_blk    = r_head;
                        n_state  = alloc_go ? ffa_pkg::S_A_RD : ffa_pkg::S_DONE;
                    end else begin
                        n_status = ffa_pkg::ST_FREE_IGN;
                        n_b      = GW'(f_gran);
                        n_state  = free_go ? ffa_pkg::S_F_RD : ffa_pkg::S_DONE;
                    end
                end
            end

            // First-fit walk
            ffa_pkg::S_A_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_blk;
                n_state   = ffa_pkg::S_A_EVAL;
            end

            ffa_pkg::S_A_EVAL: begin
                if (walk_more) begin
                    n_athead = 1'b0;
                    n_prev   = r_blk;
                    n_hp     = r_rdata;
                    n_blk    = r_rdata.next;
                    n_steps  = r_steps + 1'b1;
                    n_state  = ffa_pkg::S_A_RD;
                end else begin
                    n_hb    = r_rdata;
                    n_state = (r_blk == GW'(END_G)) ? ffa_pkg::S_DONE
                                                     : ffa_pkg::S_A_UNLINK;
                end
            end

            // Unlink the chosen block
            ffa_pkg::S_A_UNLINK: begin
                if (r_athead) begin
                    n_head = r_hb.next;
                end else begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_prev;
                    mem_wdata        = r_hp;
                    mem_wdata.next   = r_hb.next;
                    mem_wdata.linked = r_hb.linked;
                end
                n_split = split_rem > SW'(SPLIT_MIN);
                n_state = ffa_pkg::S_A_BLKW;
            end

            // Mark the block allocated, account bytes, queue the remainder
            ffa_pkg::S_A_BLKW: begin
                mem_we           = 1'b1;
                mem_waddr        = r_blk;
                mem_wdata.size   = r_split ? r_want : r_hb.size;
                mem_wdata.next   = r_hb.next;
                mem_wdata.linked = 1'b0;
                mem_wdata.used   = 1'b1;
                n_free   = r_free - mem_wdata.size;
                if (n_free < r_min) begin
                    n_min = n_free;
                end
                n_status = ffa_pkg::ST_ALLOCATED;
                n_result = 12'(gaddr(r_blk) + AW'(HEADER_BYTES));
                n_b      = r_blk + GW'(r_want >> ALSH);
                n_bsize  = split_rem;
                n_athead = 1'b1;
                n_it     = '0;
                n_nxt    = r_head;
                n_steps  = '0;
                n_state  = r_split ? ffa_pkg::S_P_CHK : ffa_pkg::S_DONE;
            end

            // Free: check the header
            ffa_pkg::S_F_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_b;
                n_state   = ffa_pkg::S_F_EVAL;
            end

            ffa_pkg::S_F_EVAL: begin
                if (r_rdata.used && !r_rdata.linked) begin
                    n_status = ffa_pkg::ST_FREED;
                    n_free   = r_free + r_rdata.size;
                    n_bsize  = r_rdata.size;
                    n_athead = 1'b1;
                    n_it     = '0;
                    n_nxt    = r_head;
                    n_steps  = '0;
                    n_state  = ffa_pkg::S_P_CHK;
                end else begin
                    n_state = ffa_pkg::S_DONE;
                end
            end

            // Reinsertion walk: find the neighbors of block b
            ffa_pkg::S_P_CHK: begin
                mem_re    = 1'b1;
                mem_raddr = r_nxt;
                if ((r_nxt < r_b) && (32'(r_steps) <= 32'(GRANULES))) begin
                    n_athead = 1'b0;
                    n_it     = r_nxt;
                    n_state  = ffa_pkg::S_P_RD;
                end else begin
                    n_state = ffa_pkg::S_P_MRG;
                end
            end

            ffa_pkg::S_P_RD: begin
                n_hit = r_rdata;
                if (!r_rdata.linked) begin
                    n_state = ffa_pkg::S_P_NRD;
                end else begin
                    n_nxt   = r_rdata.next;
                    n_steps = r_steps + 1'b1;
                    n_state = ffa_pkg::S_P_CHK;
                end
            end

            ffa_pkg::S_P_NRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_nxt;
                n_state   = ffa_pkg::S_P_MRG;
            end

            // Merge with the following block and write b
            ffa_pkg::S_P_MRG: begin
                mem_we    = 1'b1;
                mem_waddr = r_b;
                mem_wdata = pb_new;
                n_pb      = pb_new;
                n_state   = ffa_pkg::S_P_LINK;
            end

            // Merge into the preceding block or link b behind it
            ffa_pkg::S_P_LINK: begin
                if (merge_prev) begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_it;
                    mem_wdata        = r_hit;
                    mem_wdata.size   = r_hit.size + r_pb.size;
                    mem_wdata.next   = r_pb.next;
                    mem_wdata.linked = r_pb.linked;
                end else if (r_athead) begin
                    n_head = r_b;
                end else begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_it;
                    mem_wdata        = r_hit;
                    mem_wdata.next   = r_b;
                    mem_wdata.linked = 1'b1;
                end
                n_state = ffa_pkg::S_DONE;
            end

            // Hand the result to the output register
            ffa_pkg::S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oresult = r_result;
                    n_ofree   = 12'(r_free);
                    n_omin    = 12'(r_min);
                    n_state   = ffa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ffa_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffa_pkg::S_CLR;
            r_clr    <= '0;
            r_head   <= '0;
            r_free   <= SW'(INIT_FREE);
            r_min    <= SW'(INIT_FREE);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_free   <= n_free;
            r_min    <= n_min;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_blk     <= n_blk;
        r_prev    <= n_prev;
        r_athead  <= n_athead;
        r_steps   <= n_steps;
        r_want    <= n_want;
        r_hb      <= n_hb;
        r_hp      <= n_hp;
        r_split   <= n_split;
        r_b       <= n_b;
        r_bsize   <= n_bsize;
        r_it      <= n_it;
        r_nxt     <= n_nxt;
        r_hit     <= n_hit;
        r_pb      <= n_pb;
        r_status  <= n_status;
        r_result  <= n_result;
        r_ostatus <= n_ostatus;
        r_oresult <= n_oresult;
        r_ofree   <= n_ofree;
        r_omin    <= n_omin;
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_ostatus;
    assign o_rsp.result_offset  = r_oresult;
    assign o_rsp.free_bytes     = r_ofree;
    assign o_rsp.min_free_bytes = r_omin;

`ifndef SYNTHESIS
    // The low-water mark never exceeds the current free count
    a_min_le_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_free)
        else $error("min free count above free count");

    // Free count stays within the heap
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(INIT_FREE))
        else $error("free count exceeds heap");

    // No read and write of the same header in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("header read and write collide");

    // An allocation never raises the free count
    a_alloc_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_A_BLKW) |=> (r_free <= $past(r_free)))
        else $error("allocation raised free count");
`endif

endmodule

/* sim/first_fit_heap_allocator_tb.sv */
// Testbench for the first-fit heap allocator: predicts each response and checks it.

class heap_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] offset;
        logic [11:0] free_b;
        logic [11:0] min_free_b;
    } t_rsp;

    localparam int HEAP   = ffa_pkg::HEAP_BYTES_DEF;
    localparam int ALIGN  = ffa_pkg::ALIGN_BYTES_DEF;
    localparam int HDR    = ffa_pkg::HEADER_BYTES_DEF;
    localparam int NGRAN  = HEAP / ALIGN;
    localparam int END_GR = (HEAP - HDR) / ALIGN;

    int unsigned blk_size [NGRAN];
    int unsigned blk_next [NGRAN];
    bit          blk_link [NGRAN];
    bit          blk_used [NGRAN];
    int unsigned head_g;
    int unsigned free_now;
    int unsigned free_low;
    t_rsp        pending_rsp [$];
    int          errors;

    function new();
        foreach (blk_size[i]) begin
            blk_size[i] = 0; blk_next[i] = 0; blk_link[i] = 0; blk_used[i] = 0;
        end
        blk_size[0] = END_GR * ALIGN;
        blk_next[0] = END_GR;
        blk_link[0] = 1;
        head_g = 0;
        free_now = END_GR * ALIGN;
        free_low = free_now;
        errors = 0;
    endfunction

    function int unsigned gidx(int unsigned g);
        return (g < NGRAN) ? g : END_GR;
    endfunction

    // Insert block b into the address-ordered list, merging neighbors
    function void link_free(int unsigned b);
        bit          first;
        int unsigned prv, nxt, steps;
        first = 1; prv = 0; nxt = head_g; steps = 0;
        while (nxt < b && steps <= NGRAN) begin
            first = 0;
            prv = nxt;
            if (!blk_link[gidx(prv)]) break;
            nxt = blk_next[gidx(prv)];
            steps++;
        end
        if (b * ALIGN + blk_size[b] == nxt * ALIGN) begin
            if (nxt != END_GR) begin
                blk_size[b] += blk_size[gidx(nxt)];
                blk_next[b] = blk_next[gidx(nxt)];
                blk_link[b] = blk_link[gidx(nxt)];
            end else begin
                blk_next[b] = END_GR; blk_link[b] = 1;
            end
        end else begin
            blk_next[b] = nxt; blk_link[b] = 1;
        end
        if (!first && prv * ALIGN + blk_size[gidx(prv)] == b * ALIGN) begin
            blk_size[gidx(prv)] += blk_size[b];
            blk_next[gidx(prv)] = blk_next[b];
            blk_link[gidx(prv)] = blk_link[b];
            return;
        end
        if (first) head_g = b;
        else begin
            blk_next[gidx(prv)] = b; blk_link[gidx(prv)] = 1;
        end
    endfunction

    // Note an accepted request; returns allocated offset (0 if none)
    function int unsigned note_request(ffa_pkg::t_action act, int unsigned req,
                                       int unsigned poff);
        t_rsp        r;
        int unsigned want, prv, blk, steps, nb, base, g;
        bit          first;
        r.offset = 0;
        if (act == ffa_pkg::ACT_ALLOC) begin
            r.status = ffa_pkg::ST_ALLOC_FAIL;
            want = req;
            if (req > 0 && req <= HEAP - HDR) begin
                want += HDR;
                if (want % ALIGN != 0) want += ALIGN - want % ALIGN;
            end
            if (want > 0 && want <= free_now) begin
                first = 1; prv = 0; blk = head_g; steps = 0;
                while (blk_size[gidx(blk)] < want && blk_link[gidx(blk)] && steps <= NGRAN) begin
                    first = 0; prv = blk; blk = blk_next[gidx(blk)]; steps++;
                end
                if (blk != END_GR) begin
                    blk = gidx(blk);
                    r.offset = blk * ALIGN + HDR;
                    if (first) head_g = blk_next[blk];
                    else begin
                        blk_next[gidx(prv)] = blk_next[blk];
                        blk_link[gidx(prv)] = blk_link[blk];
                    end
                    if (blk_size[blk] - want > 2 * HDR) begin
                        nb = blk + want / ALIGN;
                        blk_size[gidx(nb)] = blk_size[blk] - want;
                        blk_used[gidx(nb)] = 0;
                        blk_size[blk] = want;
                        link_free(gidx(nb));
                    end
                    free_now -= blk_size[blk];
                    if (free_now < free_low) free_low = free_now;
                    blk_used[blk] = 1;
                    blk_link[blk] = 0;
                    r.status = ffa_pkg::ST_ALLOCATED;
                end
            end
        end else begin
            r.status = ffa_pkg::ST_FREE_IGN;
            if (poff != 0 && poff >= HDR) begin
                base = poff - HDR;
                g = base / ALIGN;
                if (base % ALIGN == 0 && g < NGRAN && blk_used[g] && !blk_link[g]) begin
                    blk_used[g] = 0;
                    free_now += blk_size[g];
                    link_free(g);
                    r.status = ffa_pkg::ST_FREED;
                end
            end
        end
        r.free_b = free_now[11:0];
        r.min_free_b = free_low[11:0];
        pending_rsp.push_back(r);
        return r.offset;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Compare a received response with the oldest prediction
    task check_response(t_rsp got);
        t_rsp exp_r;
        if (pending_rsp.size() == 0) begin
            report($sformatf("unexpected response %p", got));
            return;
        end
        exp_r = pending_rsp.pop_front();
        if (got.status !== exp_r.status)
            report($sformatf("status %0d want %0d", got.status, exp_r.status));
        if (got.offset !== exp_r.offset)
            report($sformatf("offset %0d want %0d", got.offset, exp_r.offset));
        if (got.free_b !== exp_r.free_b)
            report($sformatf("free %0d want %0d", got.free_b, exp_r.free_b));
        if (got.min_free_b !== exp_r.min_free_b)
            report($sformatf("min free %0d want %0d", got.min_free_b, exp_r.min_free_b));
    endtask
endclass

module first_fit_heap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    heap_scoreboard sb = new();
    int unsigned live_offs [$];
    bit  no_idle = 0;
    int  idle_cycles = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        req_ch.valid = 0;
        req_ch.action = ffa_pkg::ACT_ALLOC;
        req_ch.request_bytes = 0;
        req_ch.payload_offset = 0;
        rsp_ch.ready = 0;
    end

    // Send one request; waits for acceptance, updates the prediction
    task automatic send_req(ffa_pkg::t_action act, int unsigned req, int unsigned poff);
        int unsigned off;
        while (!no_idle && $urandom_range(99) < 29) begin
            req_ch.valid <= 0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.action <= act;
        req_ch.request_bytes <= req[15:0];
        req_ch.payload_offset <= poff[11:0];
        do @(posedge i_clk); while (!req_ch.ready);
        off = sb.note_request(act, req[15:0], poff[11:0]);
        if (off != 0) live_offs.push_back(off);
        @(negedge i_clk);
    endtask

    task automatic free_random_live();
        int k;
        int unsigned o;
        if (live_offs.size() == 0) return;
        k = $urandom_range(live_offs.size() - 1);
        o = live_offs[k];
        live_offs.delete(k);
        send_req(ffa_pkg::ACT_FREE, 0, o);
    endtask

    // Response side: random stalls, sample at the rising edge
    always @(negedge i_clk) rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.status, rsp_ch.result_offset,
                               rsp_ch.free_bytes, rsp_ch.min_free_bytes});
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT + 1000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: special cases and field extremes
        send_req(ffa_pkg::ACT_FREE, 0, 0);
        send_req(ffa_pkg::ACT_ALLOC, 0, 0);
        send_req(ffa_pkg::ACT_ALLOC, 65535, 4095);
        send_req(ffa_pkg::ACT_ALLOC, 4089, 0);
        send_req(ffa_pkg::ACT_ALLOC, 1, 0);
        send_req(ffa_pkg::ACT_ALLOC, 24, 0);
        send_req(ffa_pkg::ACT_ALLOC, 100, 0);
        send_req(ffa_pkg::ACT_ALLOC, 7, 0);
        send_req(ffa_pkg::ACT_FREE, 0, 4095);
        send_req(ffa_pkg::ACT_FREE, 0, 4);
        send_req(ffa_pkg::ACT_FREE, 0, 12);
        send_req(ffa_pkg::ACT_FREE, 0, live_offs[1]);
        send_req(ffa_pkg::ACT_FREE, 0, 32);
        send_req(ffa_pkg::ACT_FREE, 65535, 32);
        send_req(ffa_pkg::ACT_ALLOC, 3000, 0);
        send_req(ffa_pkg::ACT_ALLOC, 2000, 0);
        while (live_offs.size() > 0) free_random_live();
        send_req(ffa_pkg::ACT_ALLOC, 4088, 0);
        send_req(ffa_pkg::ACT_ALLOC, 4080, 0);
        free_random_live();

        // Random: mostly allocate/free of live blocks, some noise
        for (int i = 0; i < 950; i++) begin
            no_idle = (i >= 400 && i < 520);
            r = $urandom_range(99);
            if (r < 45) begin
                if ($urandom_range(9) == 0)
                    send_req(ffa_pkg::ACT_ALLOC, $urandom, 0);
                else if ($urandom_range(9) == 0)
                    send_req(ffa_pkg::ACT_ALLOC, $urandom_range(4096), 0);
                else
                    send_req(ffa_pkg::ACT_ALLOC, $urandom_range(1, 200), $urandom);
            end else if (r < 88 && live_offs.size() > 0) begin
                free_random_live();
            end else begin
                send_req(ffa_pkg::ACT_FREE, $urandom, $urandom);
            end
        end
        no_idle = 0;
        req_ch.valid <= 0;

        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
